// File: rtl/piece_to_file_segmenter_core_assert.svh
// assertion macros for the piece to file segmenter
`ifndef PIECE_TO_FILE_SEGMENTER_CORE_ASSERT_SVH
`define PIECE_TO_FILE_SEGMENTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("segmenter assertion failed");
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("segmenter assertion failed");
`else
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop)
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// File: rtl/ptfs_pkg.sv
// shared types and constants for the piece to file segmenter
`timescale 1ns / 1ps
`default_nettype none
package ptfs_pkg;

  localparam int MAX_FILES_DEF  = 16;
  localparam int RESULT_LIMIT   = 16;
  localparam int PIECE_W        = 27;
  localparam int FSIZE_W        = 40;
  localparam int TOTAL_W        = 44;
  localparam int FILE_NUM_W     = 4;
  localparam logic [PIECE_W-1:0] PIECE_SIZE_RST = 27'd262144;

  typedef enum logic {
    ACT_APPEND = 1'b0,
    ACT_NEXT   = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_SEGMENT    = 2'd0,
    ST_FILE_OK    = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NO_PIECE   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } walk_state_t;

  typedef struct packed {
    action_t            action;
    logic [FSIZE_W-1:0] file_size;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [TOTAL_W-1:0]    piece_number;
    logic [FILE_NUM_W-1:0] file_number;
    logic [FSIZE_W-1:0]    file_offset;
    logic [PIECE_W-1:0]    segment_length;
    logic                  last_segment;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

endpackage
`default_nettype wire

// File: rtl/ptfs_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ptfs_ram #(
  parameter int  WIDTH  = 40,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/ptfs_ctrl.sv
// sequencer: table append, piece checks and the segment walk
`timescale 1ns / 1ps
`default_nettype none
module ptfs_ctrl import ptfs_pkg::*; #(
  parameter int  MAX_FILES = MAX_FILES_DEF,
  localparam int ADDR_W    = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire in_item_t           in_item,
  input  wire logic [PIECE_W-1:0] piece_size,
  output logic                    busy,
  output emit_t                   emit,
  output logic                    ram_we,
  output logic [ADDR_W-1:0]       ram_waddr,
  output logic [FSIZE_W-1:0]      ram_wdata,
  output logic [ADDR_W-1:0]       ram_raddr,
  input  wire logic [FSIZE_W-1:0] ram_rdata
);

  localparam int FL_W  = $clog2(MAX_FILES + 1);
  localparam int CNT_W = $clog2(RESULT_LIMIT + 1);

  walk_state_t        state_r, state_nxt;
  logic [FL_W-1:0]    files_loaded_r, files_loaded_nxt;
  logic [FL_W-1:0]    cur_file_r, cur_file_nxt;
  logic [FSIZE_W-1:0] consumed_r, consumed_nxt;
  logic [TOTAL_W-1:0] bytes_rem_r, bytes_rem_nxt;
  logic [TOTAL_W-1:0] piece_cnt_r, piece_cnt_nxt;
  logic [PIECE_W-1:0] piece_left_r, piece_left_nxt;
  logic [CNT_W-1:0]   seg_cnt_r, seg_cnt_nxt;
  out_item_t          pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      files_loaded_r <= '0;
      cur_file_r     <= '0;
      consumed_r     <= '0;
      bytes_rem_r    <= '0;
      piece_cnt_r    <= '0;
      piece_left_r   <= '0;
      seg_cnt_r      <= '0;
    end else begin
      state_r        <= state_nxt;
      files_loaded_r <= files_loaded_nxt;
      cur_file_r     <= cur_file_nxt;
      consumed_r     <= consumed_nxt;
      bytes_rem_r    <= bytes_rem_nxt;
      piece_cnt_r    <= piece_cnt_nxt;
      piece_left_r   <= piece_left_nxt;
      seg_cnt_r      <= seg_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  always_comb begin
    logic [TOTAL_W:0]   sat_sum;
    logic [FSIZE_W-1:0] rest;
    logic [PIECE_W-1:0] take;
    logic               done;

    sat_sum          = '0;
    rest             = '0;
    take             = '0;
    done             = 1'b0;
    state_nxt        = state_r;
    files_loaded_nxt = files_loaded_r;
    cur_file_nxt     = cur_file_r;
    consumed_nxt     = consumed_r;
    bytes_rem_nxt    = bytes_rem_r;
    piece_cnt_nxt    = piece_cnt_r;
    piece_left_nxt   = piece_left_r;
    seg_cnt_nxt      = seg_cnt_r;
    pend_nxt         = pend_r;
    emit             = '0;
    ram_we           = 1'b0;
    ram_waddr        = files_loaded_r[ADDR_W-1:0];
    ram_wdata        = in_item.file_size;
    busy             = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_item.action == ACT_APPEND) begin
            emit.valid             = 1'b1;
            emit.item.last_segment = 1'b1;
            if (files_loaded_r >= FL_W'(MAX_FILES)) begin
              emit.item.status = ST_TABLE_FULL;
            end else begin
              ram_we                = 1'b1;
              emit.item.status      = ST_FILE_OK;
              emit.item.file_number = FILE_NUM_W'(files_loaded_r);
              files_loaded_nxt      = files_loaded_r + FL_W'(1);
              sat_sum = {1'b0, bytes_rem_r} + (TOTAL_W+1)'(in_item.file_size);
              // byte total saturates
              bytes_rem_nxt = sat_sum[TOTAL_W] ? '1 : sat_sum[TOTAL_W-1:0];
            end
          end else if (piece_size == '0 || bytes_rem_r < TOTAL_W'(piece_size)) begin
            emit.valid              = 1'b1;
            emit.item.status        = ST_NO_PIECE;
            emit.item.piece_number  = piece_cnt_r;
            emit.item.last_segment  = 1'b1;
          end else begin
            state_nxt      = S_WALK;
            piece_left_nxt = piece_size;
            seg_cnt_nxt    = '0;
          end
        end
      end
      S_WALK: begin
        if (piece_left_r == '0 || cur_file_r >= files_loaded_r ||
            seg_cnt_r == CNT_W'(RESULT_LIMIT)) begin
          done = 1'b1;
        end else if (consumed_r >= ram_rdata) begin
          // file used up (or empty): step on, unless it is the last one
          if (cur_file_r + FL_W'(1) >= files_loaded_r) begin
            done = 1'b1;
          end else begin
            cur_file_nxt = cur_file_r + FL_W'(1);
            consumed_nxt = '0;
          end
        end else begin
          rest = ram_rdata - consumed_r;
          take = (rest < FSIZE_W'(piece_left_r)) ? rest[PIECE_W-1:0] : piece_left_r;
          // the held segment goes out now that another one follows
          if (seg_cnt_r != '0) begin
            emit.valid = 1'b1;
            emit.item  = pend_r;
          end
          pend_nxt.status         = ST_SEGMENT;
          pend_nxt.piece_number   = piece_cnt_r;
          pend_nxt.file_number    = FILE_NUM_W'(cur_file_r);
          pend_nxt.file_offset    = consumed_r;
          pend_nxt.segment_length = take;
          pend_nxt.last_segment   = 1'b0;
          consumed_nxt   = consumed_r + FSIZE_W'(take);
          piece_left_nxt = piece_left_r - take;
          bytes_rem_nxt  = bytes_rem_r - TOTAL_W'(take);
          seg_cnt_nxt    = seg_cnt_r + CNT_W'(1);
        end
        if (done) begin
          state_nxt  = S_IDLE;
          emit.valid = 1'b1;
          if (seg_cnt_r == '0) begin
            emit.item.status       = ST_NO_PIECE;
            emit.item.piece_number = piece_cnt_r;
            emit.item.last_segment = 1'b1;
          end else begin
            emit.item              = pend_r;
            emit.item.last_segment = 1'b1;
            piece_cnt_nxt          = piece_cnt_r + TOTAL_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ram_raddr = cur_file_nxt[ADDR_W-1:0];
  end

endmodule
`default_nettype wire

// File: rtl/piece_to_file_segmenter_core.sv
// top level of the piece to file segmenter
`timescale 1ns / 1ps
`default_nettype none
`include "piece_to_file_segmenter_core_assert.svh"
// Splits fixed-size pieces of a concatenated file list into per-file segments.
// A request is taken when start is high and busy is low. An append request
// (action 0) stores one file length in the length table, or is refused when
// the table is full, and answers with one result in the next cycle; busy
// stays low, so appends can follow every cycle. A next-piece request that
// finds no whole piece left (or a zero piece size) answers the same way.
// Otherwise the block walks the length table, one table entry read per cycle
// through the single read port of the table memory, with busy high until the
// walk ends, and the segments come out on the way, at most one per cycle (a
// cycle that steps over a file boundary gives none), the last one marked with
// last_segment. Each result is on out_item for exactly one cycle with
// out_valid high; there is no backpressure, the receiver must take it then.
// piece_size is written through cfg_we/cfg_wdata and should only be changed
// while busy is low and no result is still due.
module piece_to_file_segmenter_core import ptfs_pkg::*; #(
  parameter int MAX_FILES = MAX_FILES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           in_item,
  // piece size register
  input  wire logic               cfg_we,
  input  wire logic [PIECE_W-1:0] cfg_wdata,
  // result channel
  output logic                    out_valid,
  output out_item_t               out_item
);

  localparam int ADDR_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;

  logic [PIECE_W-1:0] piece_size_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic               in_fire;
  emit_t              emit;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [FSIZE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [FSIZE_W-1:0] ram_rdata;

  logic               out_seg;
  logic               out_tbl;
  logic               app_fire;

  assign in_fire = start && !busy;

  // piece size register, takes effect from the next request on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piece_size_r <= PIECE_SIZE_RST;
    end else if (cfg_we) begin
      piece_size_r <= cfg_wdata;
    end
  end

  // output register: one result per cycle, strobed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_item_r <= emit.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // file length table, only loaded slots are used by the walk
  ptfs_ram #(
    .WIDTH (FSIZE_W),
    .DEPTH (MAX_FILES)
  ) u_len_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer holding the stream position and walk state
  ptfs_ctrl #(
    .MAX_FILES (MAX_FILES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_item    (in_item),
    .piece_size (piece_size_r),
    .busy       (busy),
    .emit       (emit),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // result and request classes used by the checks below
  assign out_seg  = out_valid && (out_item.status == ST_SEGMENT);
  assign out_tbl  = out_valid && (out_item.status inside {ST_FILE_OK, ST_TABLE_FULL});
  assign app_fire = in_fire && (in_item.action == ACT_APPEND);

  // any non-segment answer is the only result of its request
  `ASSERT_IMPLIES(a_single_is_last, clk, rst_n, out_valid && !out_seg, out_item.last_segment)
  // a segment that is not the last means the walk is still running
  `ASSERT_IMPLIES(a_more_means_busy, clk, rst_n, out_valid && !out_item.last_segment, busy)
  // segments always carry bytes
  `ASSERT_IMPLIES(a_seg_nonzero, clk, rst_n, out_seg, out_item.segment_length != '0)
  // table answers only follow an append request taken in the previous cycle
  `ASSERT_PROP(a_append_answer, clk, rst_n, out_tbl |-> $past(app_fire))

endmodule
`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for the piece to file segmenter core
`timescale 1ns / 1ps
module tb;
  import ptfs_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int NFILES      = MAX_FILES_DEF;
  localparam int DRAIN_WAIT  = 8;     // cycles left after the last result before a cfg write
  localparam int STALL_LIMIT = 2000;  // cycles with no request, result or cfg write
  localparam int MAX_SHOWN   = 10;
  localparam logic [PIECE_W-1:0] PIECE_MAX  = 27'd67108864;
  localparam logic [FSIZE_W-1:0] FSIZE_ONES = {FSIZE_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};

  // one line of the directed script: a request or a piece size write
  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    in_item_t           req;
    logic [PIECE_W-1:0] psize;
    logic               pinned;   // result typed in below instead of predicted
    out_item_t          pin_res;
  } script_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  in_item_t           in_item   = '0;
  logic               cfg_we    = 1'b0;
  logic [PIECE_W-1:0] cfg_wdata = '0;
  logic               busy;
  logic               out_valid;
  out_item_t          out_item;

  // sideband that travels with start: a typed-in result for this request
  logic               pin_on  = 1'b0;
  out_item_t          pin_res = '0;

  // predictor state, a private copy of what the block keeps
  logic [FSIZE_W-1:0] flen_tab [NFILES];
  logic [4:0]         files_in;
  logic [4:0]         walk_file;
  logic [FSIZE_W-1:0] walk_off;
  logic [TOTAL_W-1:0] bytes_owed;
  logic [TOTAL_W-1:0] piece_idx;
  logic [PIECE_W-1:0] psize_now;

  out_item_t   due_results [$];   // results still owed by the block, oldest first
  out_item_t   new_results [$];   // results of the request just taken
  script_row_t script [$];

  int  errors       = 0;
  int  quiet_cycles = 0;
  int  n_requests   = 0;
  int  n_results    = 0;
  int  n_segments   = 0;
  int  n_pieces     = 0;
  int  n_loaded     = 0;
  int  n_full       = 0;
  int  n_no_piece   = 0;
  int  adds_sent    = 0;
  bit  no_gaps      = 1'b0;
  bit  activity;
  out_item_t got, want;

  piece_to_file_segmenter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // append to the tail of the result queues
  function void queue_new(out_item_t x);
    new_results.insert(new_results.size(), x);
  endfunction

  function void queue_due(out_item_t x);
    due_results.insert(due_results.size(), x);
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: splits the next piece over the loaded file lengths
  // ---------------------------------------------------------------------------
  function void predict_segments(in_item_t req);
    logic [PIECE_W-1:0] left;
    logic [FSIZE_W-1:0] span;
    logic [FSIZE_W-1:0] take;
    out_item_t          r;
    out_item_t          seg;
    int                 nseg;
    bit                 stop;
    new_results.delete();
    r = '0;
    r.last_segment = 1'b1;
    if (req.action == ACT_APPEND) begin
      if (files_in >= NFILES) begin
        // table full: rejected, nothing moves
        r.status = ST_TABLE_FULL;
      end else begin
        flen_tab[files_in[FILE_NUM_W-1:0]] = req.file_size;
        r.status      = ST_FILE_OK;
        r.file_number = files_in[FILE_NUM_W-1:0];
        files_in++;
        // byte total saturates instead of wrapping
        if (TOTAL_MAX - bytes_owed < {{(TOTAL_W-FSIZE_W){1'b0}}, req.file_size})
          bytes_owed = TOTAL_MAX;
        else
          bytes_owed = bytes_owed + req.file_size;
      end
      queue_new(r);
      return;
    end
    // zero piece size or not enough bytes for a whole piece
    r.status       = ST_NO_PIECE;
    r.piece_number = piece_idx;
    if (psize_now == 0 || bytes_owed < psize_now) begin
      queue_new(r);
      return;
    end
    left = psize_now;
    nseg = 0;
    stop = 1'b0;
    while (left != 0 && walk_file < files_in && nseg < RESULT_LIMIT && !stop) begin
      if (walk_off >= flen_tab[walk_file[FILE_NUM_W-1:0]]) begin
        // file used up (or empty): step on, but never past the last loaded one
        if (walk_file + 1 >= files_in) begin
          stop = 1'b1;
        end else begin
          walk_file++;
          walk_off = '0;
        end
      end else begin
        span = flen_tab[walk_file[FILE_NUM_W-1:0]] - walk_off;
        take = (span < left) ? span : left;
        seg = '0;
        seg.status         = ST_SEGMENT;
        seg.piece_number   = piece_idx;
        seg.file_number    = walk_file[FILE_NUM_W-1:0];
        seg.file_offset    = walk_off;
        seg.segment_length = take[PIECE_W-1:0];
        queue_new(seg);
        nseg++;
        walk_off = walk_off + take;
        left     = left - take[PIECE_W-1:0];
      end
    end
    if (nseg == 0) begin
      queue_new(r);
      return;
    end
    seg = new_results.pop_back();
    seg.last_segment = 1'b1;
    queue_new(seg);
    bytes_owed = bytes_owed - (psize_now - left);
    piece_idx  = piece_idx + 1'b1;
  endfunction

  function void note_fault(string msg);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("[%0t] %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: checks results, predicts on each taken request, tracks cfg writes
  // everything is sampled at the rising edge, before that edge's updates land
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      files_in   = '0;
      walk_file  = '0;
      walk_off   = '0;
      bytes_owed = '0;
      piece_idx  = '0;
      psize_now  = PIECE_SIZE_RST;
      quiet_cycles++;
    end else begin
      activity = 1'b0;
      // a result is there for one cycle only, so it is checked right here
      if (out_valid) begin
        activity = 1'b1;
        got = out_item;
        n_results++;
        if (got.status == ST_SEGMENT) n_segments++;
        if (got.status == ST_SEGMENT && got.last_segment) n_pieces++;
        if (got.status == ST_FILE_OK) n_loaded++;
        if (got.status == ST_TABLE_FULL) n_full++;
        if (got.status == ST_NO_PIECE) n_no_piece++;
        if (due_results.size() == 0) begin
          note_fault($sformatf("result with nothing owed: st=%0d pc=%0d f=%0d",
                               got.status, got.piece_number, got.file_number));
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.piece_number !== want.piece_number ||
              got.file_number !== want.file_number ||
              got.file_offset !== want.file_offset ||
              got.segment_length !== want.segment_length ||
              got.last_segment !== want.last_segment)
            note_fault($sformatf({"mismatch exp st=%0d pc=%0d f=%0d off=%0d len=%0d last=%0d",
                                  " got st=%0d pc=%0d f=%0d off=%0d len=%0d last=%0d"},
                                 want.status, want.piece_number, want.file_number,
                                 want.file_offset, want.segment_length, want.last_segment,
                                 got.status, got.piece_number, got.file_number,
                                 got.file_offset, got.segment_length, got.last_segment));
        end
      end
      // request taken at this edge
      if (start && !busy) begin
        activity = 1'b1;
        n_requests++;
        predict_segments(in_item);
        if (pin_on)
          queue_due(pin_res);
        else
          foreach (new_results[k]) queue_due(new_results[k]);
      end
      // new piece size applies from the next request on
      if (cfg_we) begin
        activity = 1'b1;
        psize_now = cfg_wdata;
      end
      quiet_cycles = activity ? 0 : quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic script_row_t row_req(action_t a, logic [FSIZE_W-1:0] sz);
    script_row_t row;
    row = '0;
    row.kind              = ROW_REQ;
    row.req.action        = a;
    row.req.file_size     = sz;
    return row;
  endfunction

  // request whose single result is obvious enough to type in
  function automatic script_row_t row_pin(action_t a, logic [FSIZE_W-1:0] sz, status_t s,
                                          logic [TOTAL_W-1:0] pc,
                                          logic [FILE_NUM_W-1:0] fn);
    script_row_t row;
    row = row_req(a, sz);
    row.pinned                   = 1'b1;
    row.pin_res.status           = s;
    row.pin_res.piece_number     = pc;
    row.pin_res.file_number      = fn;
    row.pin_res.last_segment     = 1'b1;
    return row;
  endfunction

  function automatic script_row_t row_cfg(logic [PIECE_W-1:0] v);
    script_row_t row;
    row = '0;
    row.kind  = ROW_CFG;
    row.psize = v;
    return row;
  endfunction

  function automatic logic [FSIZE_W-1:0] small_file();
    return ($urandom_range(0, 9) == 0) ? '0 : FSIZE_W'($urandom_range(1, 1000));
  endfunction

  // present one request, with random gaps in front, and hold it until taken
  task automatic send_req(in_item_t r, logic pin = 1'b0, out_item_t pres = '0);
    while (!no_gaps && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= r;
    pin_on  <= pin;
    pin_res <= pres;
    if (r.action == ACT_APPEND) adds_sent++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // wait until every owed result is in and the walk is over, plus a margin
  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0 || busy) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_psize(logic [PIECE_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic in_item_t next_req();
    in_item_t r;
    r.action    = ACT_NEXT;
    r.file_size = FSIZE_W'({$urandom(), $urandom()});  // ignored field, random noise
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t    r;
    script_row_t row;
    int          ph;

    // directed part: empty table, zero-length files, smallest and largest
    // piece size, multi-file pieces and a piece size changed mid-stream
    script = '{
      row_pin(ACT_NEXT,   '0,         ST_NO_PIECE, '0, 4'd0),  // nothing loaded
      row_pin(ACT_APPEND, '0,         ST_FILE_OK,  '0, 4'd0),  // empty file
      row_pin(ACT_NEXT,   FSIZE_ONES, ST_NO_PIECE, '0, 4'd0),  // still no bytes
      row_cfg(27'd1),
      row_pin(ACT_APPEND, 40'd3,      ST_FILE_OK,  '0, 4'd1),
      row_pin(ACT_APPEND, 40'd0,      ST_FILE_OK,  '0, 4'd2),
      row_pin(ACT_APPEND, 40'd2,      ST_FILE_OK,  '0, 4'd3),
      row_req(ACT_NEXT, '0),   // skips the empty first file
      row_req(ACT_NEXT, '0),
      row_req(ACT_NEXT, '0),
      row_req(ACT_NEXT, '0),   // hops over the empty file in between
      row_req(ACT_NEXT, '0),
      row_req(ACT_NEXT, '0),   // stream used up
      row_cfg(PIECE_MAX),
      row_pin(ACT_APPEND, 40'd3,      ST_FILE_OK,  '0, 4'd4),
      row_req(ACT_NEXT, '0),   // far short of a whole piece
      row_cfg(27'd7),
      row_pin(ACT_APPEND, 40'd5,      ST_FILE_OK,  '0, 4'd5),
      row_pin(ACT_APPEND, 40'd0,      ST_FILE_OK,  '0, 4'd6),
      row_pin(ACT_APPEND, 40'd4,      ST_FILE_OK,  '0, 4'd7),
      row_req(ACT_NEXT, '0),   // piece over two files
      row_req(ACT_NEXT, '0),   // five bytes left, short of seven
      row_cfg(27'd5),
      row_req(ACT_NEXT, '0)    // piece over two files with an empty one between
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[k]) begin
      row = script[k];
      if (row.kind == ROW_CFG)
        write_psize(row.psize);
      else
        send_req(row.req, row.pinned, row.pin_res);
    end

    // random part: mostly next-piece requests over small files, appends mixed
    // in until one slot is left, a new piece size each phase
    for (ph = 0; ph < 6; ph++) begin
      write_psize(($urandom_range(0, 3) == 0) ? PIECE_W'($urandom_range(64, 900))
                                              : PIECE_W'($urandom_range(1, 40)));
      no_gaps = (ph == 2);   // one long stretch back to back
      repeat (17) begin
        if (adds_sent < NFILES - 1 && $urandom_range(0, 99) < 20) begin
          r.action    = ACT_APPEND;
          r.file_size = small_file();
        end else begin
          r = next_req();
        end
        send_req(r);
      end
    end
    no_gaps = 1'b0;

    // top off the table, then the largest file in the last slot
    while (adds_sent < NFILES - 1) begin
      r.action    = ACT_APPEND;
      r.file_size = small_file();
      send_req(r);
    end
    write_psize(PIECE_MAX);
    row = row_pin(ACT_APPEND, FSIZE_ONES, ST_FILE_OK, '0, 4'd15);
    send_req(row.req, row.pinned, row.pin_res);
    repeat (3) send_req(next_req());
    // table full now: appends bounce off
    repeat (2) begin
      row = row_pin(ACT_APPEND, FSIZE_W'({$urandom(), $urandom()}), ST_TABLE_FULL,
                    '0, 4'd0);
      send_req(row.req, row.pinned, row.pin_res);
    end
    // zero piece size answers no-piece, then back to the smallest
    write_psize('0);
    send_req(next_req());
    write_psize(27'd1);
    send_req(next_req());

    wait_idle();
    $display("%0d requests, %0d results: %0d segments in %0d pieces, %0d files loaded",
             n_requests, n_results, n_segments, n_pieces, n_loaded);
    $display("%0d table-full rejects, %0d no-piece answers, %0d errors",
             n_full, n_no_piece, errors);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog: too long without any request, result or cfg write
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("no activity for %0d cycles, %0d results still owed",
             quiet_cycles, due_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ptfs_pkg.sv
rtl/ptfs_ram.sv
rtl/ptfs_ctrl.sv
rtl/piece_to_file_segmenter_core.sv
tb/tb.sv
